@@ hdl/srd_pkg.sv @@
// Shared types, codes and constants of the segmented stream decryptor.
package srd_pkg;

    // Store depth used when the top level is not given one.
    localparam int MAX_KEY_LEN_DEF = 1024;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Stream layout.
    localparam logic [7:0]  HEAD_LEN    = 8'h80;
    localparam logic [12:0] SEGMENT_LEN = 13'h1400;
    localparam logic [10:0] KEY_LEN_RST = 11'd512;

    // Segment key arithmetic: 100 * hash over (s + 1) * seed.
    localparam logic [6:0] SCALE  = 7'd100;
    localparam int         DVD_W  = 39;
    localparam int         DVS_W  = 41;
    localparam int         STEP_W = 6;
    localparam int         QLOW_W = 9;
    localparam int         DISC_W = 10;

    // Control of the serial divide unit.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_H_RD,
        S_H_CHK,
        S_RED,
        S_DIV_W,
        S_HD_SEED_RD,
        S_HD_SEED,
        S_HD_KEY_RD,
        S_HD_OUT,
        S_RK_INIT,
        S_RK_MIX_RD,
        S_RK_MIX_SUM,
        S_RK_MIX_RDJ,
        S_RK_MIX_SW,
        S_RK_MIX_SW2,
        S_RK_SEED_RD,
        S_RK_SEED,
        S_RK_DISC,
        S_KS,
        S_KS_IRD,
        S_KS_A,
        S_KS_JRD,
        S_KS_SW,
        S_KS_SW2,
        S_KS_ORD,
        S_KS_OUT,
        S_EMIT
    } t_state;

endpackage

@@ hdl/segmented_rc4_stream_decrypt.sv @@
// Top level of the segmented stream decryptor: sequencer, key and permutation memories.
//
// Input channel (i_in_valid / o_in_ready) carries i_kind, i_key_index and i_byte_value.
// A load beat writes one key byte, a start beat hashes the first N key bytes and restarts
// the stream, and a data beat returns one plain byte on the output channel
// (o_out_valid / i_out_ready). The configuration channel (i_cfg_valid / o_cfg_ready)
// writes the key length N and is always ready; write it only while the block is idle.
// One item is worked on at a time; o_in_ready is high only in the idle state.
// Each modular reduction of a value of twice N or more runs in the serial divide unit.
// A head data beat (the first 128 of a stream) takes its key byte from a segment key
// found by the 39-step divide. Re-keying fills and mixes the permutation, finds the
// segment key and discards keystream bytes; all permutation work shares one memory.
// The result register frees the output while the next beat is taken; a stalled
// receiver holds the block in its emit state until the waiting beat is taken.
// Synchronous reset sets N to 512, the hash to one and the stream counters to zero;
// the memories are not cleared.
module segmented_rc4_stream_decrypt #(
    parameter int MAX_KEY_LEN = srd_pkg::MAX_KEY_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_key_index,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_plain_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import srd_pkg::*;

    localparam int AW = $clog2(MAX_KEY_LEN);
    localparam int NW = AW + 1;
    localparam int LW = (NW > 11) ? NW : 11;
    localparam int MW = ((AW > 9) ? AW : 9) + 1;
    localparam int CW = (MW > NW + 1) ? MW : NW + 1;

    // Memories.
    logic [7:0] r_key_mem  [MAX_KEY_LEN];
    logic [7:0] r_perm_mem [MAX_KEY_LEN];
    logic [7:0] r_key_q;
    logic [7:0] r_perm_q;

    // State.
    t_state            r_state, n_state;
    t_state            r_ret, n_ret;
    t_state            r_after, n_after;
    logic [10:0]       r_key_length;
    logic [31:0]       r_hash, n_hash;
    logic [AW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_j, n_j;
    logic [7:0]        r_pos, n_pos;
    logic [31:0]       r_seg, n_seg;
    logic [12:0]       r_left, n_left;
    logic [NW-1:0]     r_k, n_k;
    logic [MW-1:0]     r_mval, n_mval;
    logic [AW-1:0]     r_mres, n_mres;
    logic [QLOW_W-1:0] r_q9, n_q9;
    logic [7:0]        r_a, n_a;
    logic [DISC_W-1:0] r_disc, n_disc;
    logic              r_extra, n_extra;
    logic [7:0]        r_val, n_val;
    logic [7:0]        r_res, n_res;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;

    // Combinational helpers.
    logic [LW-1:0]     w_kl;
    logic [NW-1:0]     w_n;
    logic [CW-1:0]     w_mv, w_n_c, w_2n;
    logic [NW-1:0]     w_k_p1;
    logic [NW-1:0]     w_i_p1;
    logic [AW-1:0]     w_i_nx;
    logic [31:0]       w_hprod;
    logic              w_stop;
    logic [DVS_W-1:0]  w_sp1;
    logic [DVS_W-1:0]  w_seg_d;
    logic [DVD_W-1:0]  w_scaled;
    logic [DISC_W-1:0] w_disc;
    logic              w_key_we;
    logic [AW-1:0]     w_key_waddr, w_key_raddr;
    logic              w_perm_we;
    logic [AW-1:0]     w_perm_waddr, w_perm_raddr;
    logic [7:0]        w_perm_wdata;
    logic              w_in_ready;
    logic              w_emit;
    t_div_req          w_req;
    t_div_rsp          w_rsp;
    logic [DVD_W-1:0]  w_dividend;
    logic [DVS_W-1:0]  w_divisor;
    logic [QLOW_W-1:0] w_qlow;
    logic [AW-1:0]     w_rem;

    // Effective key length: zero acts as one, large values clamp to the store depth.
    always_comb begin
        w_kl = LW'(r_key_length);
        if (r_key_length == '0) begin
            w_n = NW'(1);
        end else if (w_kl > LW'(MAX_KEY_LEN)) begin
            w_n = NW'(MAX_KEY_LEN);
        end else begin
            w_n = NW'(w_kl);
        end
    end

    // Shared arithmetic.
    assign w_mv     = CW'(r_mval);
    assign w_n_c    = CW'(w_n);
    assign w_2n     = CW'(w_n) << 1;
    assign w_k_p1   = r_k + NW'(1);
    assign w_i_p1   = NW'(r_i) + NW'(1);
    assign w_i_nx   = (w_i_p1 == w_n) ? '0 : w_i_p1[AW-1:0];
    assign w_hprod  = r_hash * 32'(r_key_q);
    assign w_sp1    = (r_state == S_HD_SEED) ? DVS_W'(r_pos) + DVS_W'(1)
                                             : DVS_W'(r_seg) + DVS_W'(1);
    assign w_seg_d  = w_sp1 * DVS_W'(r_key_q);
    assign w_scaled = DVD_W'(r_hash) * DVD_W'(SCALE);
    assign w_disc   = DISC_W'(r_q9) + (r_extra ? DISC_W'(HEAD_LEN) : DISC_W'(0));

    // Sequencer: next state, memory ports and divide requests.
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_after      = r_after;
        n_hash       = r_hash;
        n_i          = r_i;
        n_j          = r_j;
        n_pos        = r_pos;
        n_seg        = r_seg;
        n_left       = r_left;
        n_k          = r_k;
        n_mval       = r_mval;
        n_mres       = r_mres;
        n_q9         = r_q9;
        n_a          = r_a;
        n_disc       = r_disc;
        n_extra      = r_extra;
        n_val        = r_val;
        n_res        = r_res;
        w_stop       = 1'b0;
        w_key_we     = 1'b0;
        w_key_waddr  = AW'(i_key_index);
        w_key_raddr  = r_k[AW-1:0];
        w_perm_we    = 1'b0;
        w_perm_waddr = r_i;
        w_perm_wdata = r_perm_q;
        w_perm_raddr = r_i;
        w_in_ready   = 1'b0;
        w_emit       = 1'b0;
        w_req.start  = 1'b0;
        w_req.steps  = STEP_W'(MW);
        w_dividend   = DVD_W'(r_mval) << (DVD_W - MW);
        w_divisor    = DVS_W'(1);

        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_kind)
                        KIND_LOAD: begin
                            w_key_we = (32'(i_key_index) < 32'(MAX_KEY_LEN));
                        end
                        KIND_START: begin
                            n_hash  = 32'd1;
                            n_k     = '0;
                            n_state = S_H_RD;
                        end
                        KIND_DATA: begin
                            n_val = i_byte_value;
                            if (r_pos < HEAD_LEN) begin
                                n_mval  = MW'(r_pos);
                                n_ret   = S_HD_SEED_RD;
                                n_state = S_RED;
                            end else if (r_left == '0) begin
                                n_extra = 1'b0;
                                n_after = S_KS;
                                n_disc  = '0;
                                n_k     = '0;
                                n_state = S_RK_INIT;
                            end else begin
                                n_disc  = '0;
                                n_state = S_KS;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Key hash: one key byte read and one multiply per key byte.
            S_H_RD: begin
                w_key_raddr = r_k[AW-1:0];
                n_state     = S_H_CHK;
            end
            S_H_CHK: begin
                if (r_key_q != 8'd0) begin
                    if (w_hprod == 32'd0 || w_hprod <= r_hash) begin
                        w_stop = 1'b1;
                    end else begin
                        n_hash = w_hprod;
                    end
                end
                if (w_stop || w_k_p1 == w_n) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_pos   = '0;
                    n_seg   = '0;
                    n_left  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k     = w_k_p1;
                    n_state = S_H_RD;
                end
            end

            // Reduction of r_mval modulo N; large values go through the divide unit.
            S_RED: begin
                if (w_mv < w_n_c) begin
                    n_mres  = r_mval[AW-1:0];
                    n_state = r_ret;
                end else if (w_mv < w_2n) begin
                    n_mres  = AW'(w_mv - w_n_c);
                    n_state = r_ret;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = S_DIV_W;
                end
            end
            S_DIV_W: begin
                if (w_rsp.done) begin
                    n_mres  = w_rem;
                    n_q9    = w_qlow;
                    n_state = r_ret;
                end
            end

            // Head bytes: key byte chosen by the segment key of the position.
            S_HD_SEED_RD: begin
                w_key_raddr = r_mres;
                n_state     = S_HD_SEED;
            end
            S_HD_SEED: begin
                if (r_key_q == 8'd0) begin
                    n_mres  = '0;
                    n_state = S_HD_KEY_RD;
                end else begin
                    w_req.start = 1'b1;
                    w_req.steps = STEP_W'(DVD_W);
                    w_dividend  = w_scaled;
                    w_divisor   = w_seg_d;
                    n_ret       = S_HD_KEY_RD;
                    n_state     = S_DIV_W;
                end
            end
            S_HD_KEY_RD: begin
                w_key_raddr = r_mres;
                n_state     = S_HD_OUT;
            end
            S_HD_OUT: begin
                n_res = r_val ^ r_key_q;
                n_pos = r_pos + 8'd1;
                if (r_pos == HEAD_LEN - 8'd1) begin
                    n_left  = '0;
                    n_extra = 1'b1;
                    n_after = S_EMIT;
                    n_k     = '0;
                    n_state = S_RK_INIT;
                end else begin
                    n_state = S_EMIT;
                end
            end

            // Re-key: fill the permutation, one entry a cycle.
            S_RK_INIT: begin
                n_i          = '0;
                n_j          = '0;
                w_perm_we    = 1'b1;
                w_perm_waddr = r_k[AW-1:0];
                w_perm_wdata = 8'(r_k);
                if (w_k_p1 == w_n) begin
                    n_k     = '0;
                    n_state = S_RK_MIX_RD;
                end else begin
                    n_k = w_k_p1;
                end
            end

            // Key schedule mix: read, reduce, read partner, swap in two writes.
            S_RK_MIX_RD: begin
                w_perm_raddr = r_k[AW-1:0];
                w_key_raddr  = r_k[AW-1:0];
                n_state      = S_RK_MIX_SUM;
            end
            S_RK_MIX_SUM: begin
                n_a     = r_perm_q;
                n_mval  = MW'(r_perm_q) + MW'(r_j) + MW'(r_key_q);
                n_ret   = S_RK_MIX_RDJ;
                n_state = S_RED;
            end
            S_RK_MIX_RDJ: begin
                n_j          = r_mres;
                w_perm_raddr = r_mres;
                n_state      = S_RK_MIX_SW;
            end
            S_RK_MIX_SW: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_k[AW-1:0];
                w_perm_wdata = r_perm_q;
                n_state      = S_RK_MIX_SW2;
            end
            S_RK_MIX_SW2: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_j;
                w_perm_wdata = r_a;
                if (w_k_p1 == w_n) begin
                    n_k     = '0;
                    n_j     = '0;
                    n_mval  = MW'(r_seg[QLOW_W-1:0]);
                    n_ret   = S_RK_SEED_RD;
                    n_state = S_RED;
                end else begin
                    n_k     = w_k_p1;
                    n_state = S_RK_MIX_RD;
                end
            end

            // Segment key of the segment number sets the discard count.
            S_RK_SEED_RD: begin
                w_key_raddr = r_mres;
                n_state     = S_RK_SEED;
            end
            S_RK_SEED: begin
                if (r_key_q == 8'd0) begin
                    n_q9    = '0;
                    n_state = S_RK_DISC;
                end else begin
                    w_req.start = 1'b1;
                    w_req.steps = STEP_W'(DVD_W);
                    w_dividend  = w_scaled;
                    w_divisor   = w_seg_d;
                    n_ret       = S_RK_DISC;
                    n_state     = S_DIV_W;
                end
            end
            S_RK_DISC: begin
                n_disc = w_disc;
                n_left = r_extra ? SEGMENT_LEN - 13'(HEAD_LEN) : SEGMENT_LEN;
                n_seg  = r_seg + 32'd1;
                if (w_disc == '0) begin
                    n_state = r_after;
                end else begin
                    n_state = S_KS;
                end
            end

            // Keystream byte: advance i, read S[i], reduce j, swap, read output.
            // An index left beyond a shortened key length is reduced first.
            S_KS: begin
                if (w_i_p1 > w_n) begin
                    n_mval  = MW'(w_i_p1);
                    n_ret   = S_KS_IRD;
                    n_state = S_RED;
                end else begin
                    w_perm_raddr = w_i_nx;
                    n_i          = w_i_nx;
                    n_state      = S_KS_A;
                end
            end
            S_KS_IRD: begin
                w_perm_raddr = r_mres;
                n_i          = r_mres;
                n_state      = S_KS_A;
            end
            S_KS_A: begin
                n_a     = r_perm_q;
                n_mval  = MW'(r_perm_q) + MW'(r_j);
                n_ret   = S_KS_JRD;
                n_state = S_RED;
            end
            S_KS_JRD: begin
                n_j          = r_mres;
                w_perm_raddr = r_mres;
                n_state      = S_KS_SW;
            end
            S_KS_SW: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_i;
                w_perm_wdata = r_perm_q;
                n_mval       = MW'(r_a) + MW'(r_perm_q);
                n_state      = S_KS_SW2;
            end
            S_KS_SW2: begin
                w_perm_we    = 1'b1;
                w_perm_waddr = r_j;
                w_perm_wdata = r_a;
                n_ret        = S_KS_ORD;
                n_state      = S_RED;
            end
            S_KS_ORD: begin
                w_perm_raddr = r_mres;
                n_state      = S_KS_OUT;
            end
            S_KS_OUT: begin
                if (r_disc != '0) begin
                    n_disc  = r_disc - DISC_W'(1);
                    n_state = (r_disc == DISC_W'(1)) ? r_after : S_KS;
                end else begin
                    n_res   = r_val ^ r_perm_q;
                    n_left  = r_left - 13'd1;
                    n_state = S_EMIT;
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_after      <= S_IDLE;
            r_key_length <= KEY_LEN_RST;
            r_hash       <= 32'd1;
            r_i          <= '0;
            r_j          <= '0;
            r_pos        <= '0;
            r_seg        <= '0;
            r_left       <= '0;
            r_k          <= '0;
            r_disc       <= '0;
            r_extra      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_after <= n_after;
            r_hash  <= n_hash;
            r_i     <= n_i;
            r_j     <= n_j;
            r_pos   <= n_pos;
            r_seg   <= n_seg;
            r_left  <= n_left;
            r_k     <= n_k;
            r_disc  <= n_disc;
            r_extra <= n_extra;
            if (i_cfg_valid) begin
                r_key_length <= i_cfg_data;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_mval <= n_mval;
        r_mres <= n_mres;
        r_q9   <= n_q9;
        r_a    <= n_a;
        r_val  <= n_val;
        r_res  <= n_res;
    end

    // Key memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_key_waddr] <= i_byte_value;
        end
        r_key_q <= r_key_mem[w_key_raddr];
    end

    // Permutation memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_perm_we) begin
            r_perm_mem[w_perm_waddr] <= w_perm_wdata;
        end
        r_perm_q <= r_perm_mem[w_perm_raddr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= r_res;
        end
    end

    srd_divmod #(
        .MAX_KEY_LEN(MAX_KEY_LEN)
    ) u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_modulus  (w_n),
        .o_rsp      (w_rsp),
        .o_quot_low (w_qlow),
        .o_rem      (w_rem)
    );

    assign o_in_ready   = w_in_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_out_byte;

endmodule

@@ hdl/srd_divmod.sv @@
// Serial restoring divider whose quotient bits are also reduced modulo the key length.
module srd_divmod #(
    parameter int MAX_KEY_LEN = srd_pkg::MAX_KEY_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srd_pkg::t_div_req                 i_req,
    input  logic [srd_pkg::DVD_W-1:0]         i_dividend,
    input  logic [srd_pkg::DVS_W-1:0]         i_divisor,
    input  logic [$clog2(MAX_KEY_LEN):0]      i_modulus,
    output srd_pkg::t_div_rsp                 o_rsp,
    output logic [srd_pkg::QLOW_W-1:0]        o_quot_low,
    output logic [$clog2(MAX_KEY_LEN)-1:0]    o_rem
);
    import srd_pkg::*;

    localparam int AW = $clog2(MAX_KEY_LEN);
    localparam int NW = AW + 1;

    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [NW-1:0]     r_acc;
    logic [QLOW_W-1:0] r_q;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0]    w_trial;
    logic              w_qb;
    logic [DVS_W-1:0]  w_rem_nx;
    logic [NW:0]       w_acc2;
    logic [NW-1:0]     w_acc_nx;

    // One quotient bit per cycle; the bit is folded into a running residue mod N.
    always_comb begin
        w_trial  = {r_rem, r_dvd[DVD_W-1]};
        w_qb     = (w_trial >= {1'b0, r_dvs});
        w_rem_nx = w_qb ? DVS_W'(w_trial - {1'b0, r_dvs}) : DVS_W'(w_trial);
        w_acc2   = {r_acc, w_qb};
        w_acc_nx = (w_acc2 >= {1'b0, i_modulus}) ? NW'(w_acc2 - {1'b0, i_modulus})
                                                 : NW'(w_acc2);
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_acc <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_rem_nx;
            r_acc <= w_acc_nx;
            r_q   <= {r_q[QLOW_W-2:0], w_qb};
        end
    end

    assign o_rsp.done = r_done;
    assign o_quot_low = r_q;
    assign o_rem      = r_acc[AW-1:0];

endmodule

@@ verif/srd_checker.sv @@
// Checker for the segmented stream decryptor: it predicts each plain byte and compares it.
`timescale 1ns / 1ps

module srd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_key_index,
    input  logic [7:0]  i_byte_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_plain_byte,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import srd_pkg::*;

    localparam int unsigned DEPTH = 1024;

    // Shadow copy of the decryptor state.
    logic [7:0]  key_mem [DEPTH];
    logic [7:0]  perm_mem [DEPTH];
    logic [31:0] hash_r;
    int unsigned ks_i, ks_j, pos_r, seg_num, seg_left;
    logic [10:0] len_r;
    logic [7:0]  plain_q [$];

    function automatic int unsigned active_len();
        int unsigned n;
        n = len_r;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    // Segment key, exact integer form of 100 * hash / ((s + 1) * seed).
    function automatic longint unsigned seg_key(longint unsigned s, longint unsigned seed);
        longint unsigned d;
        d = (s + 1) * seed;
        if (d == 0) return 0;
        return (longint'(hash_r) * 100) / d;
    endfunction

    function automatic logic [7:0] keystream_byte(int unsigned n);
        logic [7:0] t;
        ks_i = (ks_i + 1) % n;
        ks_j = (perm_mem[ks_i] + ks_j) % n;
        t = perm_mem[ks_i];
        perm_mem[ks_i] = perm_mem[ks_j];
        perm_mem[ks_j] = t;
        return perm_mem[(perm_mem[ks_i] + perm_mem[ks_j]) % n];
    endfunction

    // Refill and mix the permutation, then skip the segment's discard count.
    function automatic void rekey(int unsigned n, int unsigned extra);
        int unsigned j, drops;
        logic [7:0] t;
        logic [7:0] ks;
        ks_i = 0;
        ks_j = 0;
        j = 0;
        for (int unsigned k = 0; k < n; k++) perm_mem[k] = k[7:0];
        for (int unsigned k = 0; k < n; k++) begin
            j = (perm_mem[k] + j + key_mem[k]) % n;
            t = perm_mem[k];
            perm_mem[k] = perm_mem[j];
            perm_mem[j] = t;
        end
        drops = extra + int'(seg_key(seg_num, key_mem[(seg_num & 32'h1FF) % n]) & 64'h1FF);
        seg_left = SEGMENT_LEN - extra;
        for (int unsigned k = 0; k < drops; k++) ks = keystream_byte(n);
        seg_num = seg_num + 1;
    endfunction

    function automatic void compute_hash(int unsigned n);
        logic [31:0] h, t;
        h = 1;
        for (int unsigned k = 0; k < n; k++) begin
            if (key_mem[k] != 0) begin
                t = h * {24'd0, key_mem[k]};
                if (t == 0 || t <= h) break;
                h = t;
            end
        end
        hash_r = h;
    endfunction

    function automatic void apply_beat(logic [1:0] kind, logic [9:0] idx, logic [7:0] val);
        int unsigned n, p;
        longint unsigned sk;
        logic [7:0] res;
        n = active_len();
        case (kind)
            KIND_LOAD: begin
                key_mem[idx] = val;
            end
            KIND_START: begin
                compute_hash(n);
                ks_i = 0;
                ks_j = 0;
                pos_r = 0;
                seg_num = 0;
                seg_left = 0;
            end
            KIND_DATA: begin
                if (pos_r < HEAD_LEN) begin
                    p = pos_r;
                    sk = seg_key(p, key_mem[p % n]);
                    res = val ^ key_mem[sk % n];
                    pos_r = p + 1;
                    if (pos_r == HEAD_LEN) begin
                        seg_left = 0;
                        rekey(n, HEAD_LEN);
                    end
                end else begin
                    if (seg_left == 0) rekey(n, 0);
                    res = val ^ keystream_byte(n);
                    seg_left = (seg_left - 1) & 32'h1FFF;
                end
                plain_q.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    // Compare output beats first, then fold in the beats taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hash_r = 1;
            ks_i = 0;
            ks_j = 0;
            pos_r = 0;
            seg_num = 0;
            seg_left = 0;
            len_r = KEY_LEN_RST;
            plain_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (plain_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected plain byte %02h", i_plain_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (plain_q[0] !== i_plain_byte) begin
                        if (o_fail_count < 10)
                            $display("plain byte mismatch: expected %02h actual %02h",
                                     plain_q[0], i_plain_byte);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(plain_q.pop_front());
                end
            end
            if (i_cfg_valid && i_cfg_ready) len_r = i_cfg_data;
            if (i_in_valid && i_in_ready) apply_beat(i_kind, i_key_index, i_byte_value);
        end
        o_pending <= plain_q.size();
    end

endmodule

@@ verif/segmented_rc4_stream_decrypt_tb.sv @@
// Testbench top: drives the decryptor with key loads, stream starts and data, and reports.
`timescale 1ns / 1ps

module segmented_rc4_stream_decrypt_tb;
    import srd_pkg::*;

    localparam int PHASE_ITEMS = 60;
    localparam int LONG_ITEMS  = 200;
    localparam int SETTLE      = 6000;
    localparam int CYCLE_LIMIT = 5000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = KIND_LOAD;
    logic [9:0]  i_key_index = '0;
    logic [7:0]  i_byte_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_plain_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          quiet = 1'b0;

    always #10 i_clk = ~i_clk;

    segmented_rc4_stream_decrypt u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_kind(i_kind), .i_key_index(i_key_index), .i_byte_value(i_byte_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_plain_byte(o_plain_byte),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    srd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_kind(i_kind), .i_key_index(i_key_index), .i_byte_value(i_byte_value),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_plain_byte(o_plain_byte),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 21);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one beat; returns in the step of its accepting edge so the next beat can follow.
    task automatic send_beat(logic [1:0] kind, logic [9:0] idx, logic [7:0] val);
        if (!quiet && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_key_index  <= idx;
        i_byte_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop presenting, let every plain byte drain and the block fall idle.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_key_length(logic [10:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] key_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) return 8'd0;
        if (r < 35) return 8'd1;
        return 8'($urandom);
    endfunction

    // Random mix, mostly data; without restarts a stream gets past the head into the
    // keystream.
    task automatic random_beats(int count, bit restarts);
        int unsigned r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 75)      send_beat(KIND_DATA, 10'($urandom), 8'($urandom));
            else if (r < 88) send_beat(KIND_LOAD, 10'($urandom), key_value());
            else if (r < 92) send_beat(restarts ? KIND_START : KIND_DATA,
                                       10'($urandom), 8'($urandom));
            else if (r < 95) send_beat(2'd3, 10'($urandom), 8'($urandom));
            else             send_beat(KIND_DATA, 10'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [10:0] lengths [8];
        lengths = '{11'd512, 11'd1, 11'd0, 11'd2047, 11'd1024, 11'd2, 11'd300, 11'd0};
        lengths[7] = 11'($urandom_range(1, 64));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole key store so every length reads only written bytes.
        for (int k = 0; k < 1024; k++) send_beat(KIND_LOAD, 10'(k), key_value());

        // Directed: data before any start, ignored kind, field extremes, then a start.
        send_beat(KIND_DATA, 10'd0, 8'h00);
        send_beat(KIND_DATA, 10'h3FF, 8'hFF);
        send_beat(KIND_DATA, 10'd0, 8'h5A);
        send_beat(2'd3, 10'h3FF, 8'hFF);
        send_beat(KIND_LOAD, 10'h3FF, 8'hFF);
        send_beat(KIND_LOAD, 10'd0, 8'hFF);
        send_beat(KIND_START, 10'd0, 8'h00);
        send_beat(KIND_DATA, 10'd0, 8'hFF);
        send_beat(KIND_DATA, 10'd0, 8'h00);

        // Phases over several key lengths, the extremes and out-of-range values among them.
        // Two long phases run one stream well into the keystream.
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                settle_block();
                write_key_length(lengths[p]);
            end
            quiet = (p == 4);
            send_beat(KIND_START, 10'($urandom), 8'($urandom));
            if (p == 0 || p == 4) random_beats(LONG_ITEMS, 1'b0);
            else                  random_beats(PHASE_ITEMS, 1'b1);
        end
        quiet = 1'b0;
        settle_block();

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
